/* src/assert_macros.svh */
// Concurrent assertion helpers, compiled out when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Check that cons holds in the same cycle as ante.
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");
// Check that cons holds in the cycle after ante.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

/* src/mwdr_pkg.sv */
`default_nettype none
package mwdr_pkg;

  // Signed working width of the small arithmetic (averages, schedule, factor).
  localparam int DW         = 40;
  localparam int HIST_DEPTH = 17;
  localparam int SCALE      = 10000;
  localparam int BIG_W      = 256;

  localparam logic [2:0] MODE_NONE      = 3'd0;
  localparam logic [2:0] MODE_EMERG_UP  = 3'd1;
  localparam logic [2:0] MODE_EMERG_DN  = 3'd2;
  localparam logic [2:0] MODE_UP        = 3'd3;
  localparam logic [2:0] MODE_DN        = 3'd4;

  localparam logic [1:0] REG_SPACING  = 2'd0;
  localparam logic [1:0] REG_INTERVAL = 2'd1;
  localparam logic [1:0] REG_LIMIT    = 2'd2;
  localparam logic [1:0] REG_GENESIS  = 2'd3;

  typedef struct packed {
    logic                 start;
    logic signed [DW-1:0] dividend;
    logic        [DW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic signed [DW-1:0] quot;
  } div_rsp_t;

endpackage
`default_nettype wire

/* src/mwdr_div.sv */
`default_nettype none
// Bit-serial signed divider, quotient truncated toward zero. Divisor must be positive.
module mwdr_div import mwdr_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire div_req_t req_i,
  output div_rsp_t      rsp_o
);

  localparam int CW = $clog2(DW + 1);

  logic          busy_q, done_q, neg_q;
  logic [CW-1:0] cnt_q;
  logic [DW-1:0] quo_q, rem_q, dsr_q;
  logic [DW-1:0] mag;
  logic [DW:0]   trial, diff;
  logic          ge;

  always_comb begin
    mag   = req_i.dividend[DW-1] ? DW'(-req_i.dividend) : DW'(req_i.dividend);
    trial = {rem_q, quo_q[DW-1]};
    diff  = trial - {1'b0, dsr_q};
    ge    = trial >= {1'b0, dsr_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CW'(1));
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(DW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= mag;
      rem_q <= '0;
      dsr_q <= req_i.divisor;
      neg_q <= req_i.dividend[DW-1];
    end else if (busy_q) begin
      rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
      quo_q <= {quo_q[DW-2:0], ge};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = neg_q ? -$signed(quo_q) : $signed(quo_q);

endmodule
`default_nettype wire

/* src/multi_window_difficulty_retarget.sv */
`default_nettype none
// Channel   Direction  Handshake                Payload
// in        input      in_valid_i/in_ready_o    block_time_i, block_bits_i
// out       output     out_valid_o/out_ready_i  next_bits_o, adjust_mode_o, fell_back_o
// cfg       input      cfg_we_i (no wait)       cfg_index_i, cfg_data_i
//
// One item walks the timestamp ring, then runs eight to ten passes of the serial
// divider, the bit-serial long division of the 256-bit target (skipped on a unit
// factor or a fault), a word-serial multiply/compare over eight 32-bit words and
// the re-encoding. The serial divider takes most of the time.
// Reset clears the FSM and history count and presets the config; history stays unknown.
// A finished item waits in the output register; the next item is taken meanwhile.
module multi_window_difficulty_retarget import mwdr_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [31:0] block_time_i,
  input  wire logic [31:0] block_bits_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      next_bits_o,
  output logic [2:0]       adjust_mode_o,
  output logic             fell_back_o,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i
);

`include "assert_macros.svh"

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SUM    = 4'd1;
  localparam logic [3:0] S_SCHED  = 4'd2;
  localparam logic [3:0] S_DSTART = 4'd3;
  localparam logic [3:0] S_DWAIT  = 4'd4;
  localparam logic [3:0] S_WANT   = 4'd5;
  localparam logic [3:0] S_MODE   = 4'd6;
  localparam logic [3:0] S_PREP   = 4'd7;
  localparam logic [3:0] S_BIG    = 4'd8;
  localparam logic [3:0] S_MUL    = 4'd9;
  localparam logic [3:0] S_CLAMP  = 4'd10;
  localparam logic [3:0] S_ENC    = 4'd11;
  localparam logic [3:0] S_DONE   = 4'd12;

  // Divider jobs, run in this order (blend only when the schedule is near, factor only when a mode applies).
  localparam logic [3:0] OP_A5    = 4'd0;
  localparam logic [3:0] OP_A7    = 4'd1;
  localparam logic [3:0] OP_A9    = 4'd2;
  localparam logic [3:0] OP_A17   = 4'd3;
  localparam logic [3:0] OP_FAST  = 4'd4;
  localparam logic [3:0] OP_SLOW  = 4'd5;
  localparam logic [3:0] OP_BLEND = 4'd6;
  localparam logic [3:0] OP_TF    = 4'd7;
  localparam logic [3:0] OP_TS    = 4'd8;
  localparam logic [3:0] OP_FACT  = 4'd9;

  localparam logic [32:0] FACTOR_ONE = 33'(SCALE);

  // Configuration registers
  logic [16:0] sp_q;
  logic [15:0] ai_q;
  logic [31:0] lim_c_q;
  logic [31:0] gen_q;

  // Control
  logic [3:0] state_q, state_d;
  logic [3:0] op_q, op_d;
  logic [7:0] ctr_q, ctr_d;
  logic [4:0] hcnt_q, hcnt_d;
  logic [4:0] vsh_q, vsh_d, lsh_q, lsh_d;
  logic       out_valid_q, out_valid_d;

  // Payload
  logic [31:0] hist_q [HIST_DEPTH];
  logic [31:0] time_q, time_d;
  logic [31:0] newer_q, newer_d, oldest_q, oldest_d;
  logic signed [DW-1:0] a5_q, a5_d, a7_q, a7_d, a9_q, a9_d, a17_q, a17_d;
  logic signed [DW-1:0] sched_q, sched_d, fast_q, fast_d, slow_q, slow_d;
  logic signed [DW-1:0] want_q, want_d, bnum_q, bnum_d, tf_q, tf_d, ts_q, ts_d;
  logic signed [DW-1:0] num_q, num_d, den_q, den_d;
  logic [32:0]  factor_q, factor_d;
  logic [32:0]  rem_q, rem_d;
  logic [13:0]  mul_q, mul_d, carry_q, carry_d;
  logic         gt_q, gt_d, fault_q, fault_d;
  logic [2:0]   mode_q, mode_d;
  logic [BIG_W-1:0] val_q, val_d, lim_q, lim_d;
  logic [31:0]  nbits_q, nbits_d;
  logic [2:0]   omode_q, omode_d;
  logic         ofault_q, ofault_d;

  // Divider
  div_req_t dreq;
  div_rsp_t drsp;

  // Combinational helpers
  logic                 in_acc;
  logic [260:0]         dec_v, dec_l;
  logic signed [DW-1:0] d_sum, sp_s, ai_s, now_s, dlt, dabs, reg_sel;
  logic [DW-1:0]        cdiv;
  logic [21:0]          cnt_sp;
  logic signed [17:0]   rem_n, dabs_n, sp_n, pick_n;
  logic signed [35:0]   bprod_a, bprod_b;
  logic [33:0]          btrial, bdiff;
  logic [45:0]          prod;
  logic [23:0]          comp;
  logic [5:0]           nsize;
  logic                 c_eu, c_ed, c_u, c_dn;

  // Start a compact decode: returns {remaining byte shifts, value before shifting}.
  function automatic logic [260:0] dec_start(input logic [31:0] c);
    logic [7:0]  sz;
    logic [22:0] w;
    logic [1:0]  rs;
    logic [7:0]  ls;
    logic [260:0] r;
    sz = c[31:24];
    w  = c[22:0];
    rs = 2'(8'd3 - sz);
    ls = sz - 8'd3;
    if (sz <= 8'd3) begin
      r = {5'd0, 233'd0, w >> {rs, 3'b000}};
    end else if (ls >= 8'd32) begin
      r = '0;
    end else begin
      r = {ls[4:0], 233'd0, w};
    end
    return r;
  endfunction

  mwdr_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (dreq),
    .rsp_o  (drsp)
  );

  assign in_ready_o    = (state_q == S_IDLE);
  assign in_acc        = in_valid_i && in_ready_o;
  assign out_valid_o   = out_valid_q;
  assign next_bits_o   = nbits_q;
  assign adjust_mode_o = omode_q;
  assign fell_back_o   = ofault_q;

  always_comb begin
    sp_s   = $signed(DW'(sp_q));
    ai_s   = $signed(DW'(ai_q));
    now_s  = $signed(DW'(time_q));
    cnt_sp = hcnt_q * sp_q;
    d_sum  = $signed(DW'({1'b0, newer_q})) - $signed(DW'({1'b0, hist_q[0]}));
    dec_v  = dec_start(block_bits_i);
    dec_l  = dec_start(lim_c_q);
    btrial = {rem_q, val_q[BIG_W-1]};
    bdiff  = btrial - {1'b0, factor_q};
    prod   = 46'(val_q[31:0]) * 46'(mul_q) + 46'(carry_q);
    comp   = val_q[BIG_W-1 -: 24];
    nsize  = 6'd32 - ctr_q[5:0];
    if (comp[23]) begin
      comp  = comp >> 8;
      nsize = nsize + 6'd1;
    end

    // Window divisors: history length, capped by window size; one when empty.
    cdiv = DW'(1);
    case (op_q)
      OP_A5:   if (hcnt_q != 5'd0) cdiv = DW'((hcnt_q < 5'd5) ? hcnt_q : 5'd5);
      OP_A7:   if (hcnt_q != 5'd0) cdiv = DW'((hcnt_q < 5'd7) ? hcnt_q : 5'd7);
      OP_A9:   if (hcnt_q != 5'd0) cdiv = DW'((hcnt_q < 5'd9) ? hcnt_q : 5'd9);
      OP_A17:  if (hcnt_q != 5'd0) cdiv = DW'(hcnt_q);
      OP_FAST: cdiv = DW'(10);
      OP_SLOW: cdiv = DW'(10);
      OP_BLEND: cdiv = DW'(ai_q);
      OP_TF:   cdiv = DW'(3);
      OP_TS:   cdiv = DW'(2);
      OP_FACT: cdiv = DW'(den_q);
      default: cdiv = DW'(1);
    endcase

    dreq.start    = (state_q == S_DSTART);
    dreq.divisor  = cdiv;
    case (op_q)
      OP_A5:    dreq.dividend = a5_q;
      OP_A7:    dreq.dividend = a7_q;
      OP_A9:    dreq.dividend = a9_q;
      OP_A17:   dreq.dividend = a17_q;
      OP_FAST:  dreq.dividend = sp_s * DW'(9);
      OP_SLOW:  dreq.dividend = sp_s * DW'(11);
      OP_BLEND: dreq.dividend = bnum_q;
      OP_TF:    dreq.dividend = want_q <<< 1;
      OP_TS:    dreq.dividend = want_q * DW'(3);
      OP_FACT:  dreq.dividend = num_q * DW'(SCALE);
      default:  dreq.dividend = '0;
    endcase

    // Branch conditions on the four window averages.
    c_eu = (a5_q < tf_q) && (a7_q < tf_q) && (a9_q < tf_q) && (a17_q < want_q);
    c_ed = (a5_q > ts_q) && (a7_q > ts_q) && (a9_q > ts_q) && (a17_q > want_q);
    c_u  = (a5_q < want_q) && (a7_q < want_q) && (a9_q < want_q) && (a17_q < want_q);
    c_dn = (a5_q > want_q) && (a7_q > want_q) && (a9_q > want_q) && (a17_q > want_q);
    dlt  = now_s - sched_q;

    // Blend numerator: the distance to the schedule is below one adjust
    // interval, so every operand fits in 18 bits.
    dabs    = dlt[DW-1] ? -dlt : dlt;
    rem_n   = 18'(ai_s - dabs);
    dabs_n  = 18'(dabs);
    sp_n    = $signed({1'b0, sp_q});
    pick_n  = (dlt > 0) ? fast_q[17:0] : slow_q[17:0];
    bprod_a = rem_n * sp_n;
    bprod_b = dabs_n * pick_n;
  end

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    ctr_d       = ctr_q;
    hcnt_d      = hcnt_q;
    out_valid_d = out_valid_q;
    time_d      = time_q;
    newer_d     = newer_q;
    oldest_d    = oldest_q;
    a5_d        = a5_q;
    a7_d        = a7_q;
    a9_d        = a9_q;
    a17_d       = a17_q;
    sched_d     = sched_q;
    fast_d      = fast_q;
    slow_d      = slow_q;
    want_d      = want_q;
    bnum_d      = bnum_q;
    tf_d        = tf_q;
    ts_d        = ts_q;
    num_d       = num_q;
    den_d       = den_q;
    factor_d    = factor_q;
    rem_d       = rem_q;
    mul_d       = mul_q;
    carry_d     = carry_q;
    gt_d        = gt_q;
    fault_d     = fault_q;
    mode_d      = mode_q;
    nbits_d     = nbits_q;
    omode_d     = omode_q;
    ofault_d    = ofault_q;
    reg_sel     = '0;
    val_d       = val_q;
    lim_d       = lim_q;
    vsh_d       = vsh_q;
    lsh_d       = lsh_q;

    // Finish compact decodes one byte a cycle; done long before the values are used.
    if (vsh_q != 5'd0) begin
      val_d = {val_q[BIG_W-9:0], 8'd0};
      vsh_d = vsh_q - 5'd1;
    end
    if (lsh_q != 5'd0) begin
      lim_d = {lim_q[BIG_W-9:0], 8'd0};
      lsh_d = lsh_q - 5'd1;
    end

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          time_d   = block_time_i;
          newer_d  = block_time_i;
          oldest_d = block_time_i;
          a5_d     = '0;
          a7_d     = '0;
          a9_d     = '0;
          a17_d    = '0;
          fault_d  = 1'b0;
          mode_d   = MODE_NONE;
          ctr_d    = '0;
          val_d    = dec_v[BIG_W-1:0];
          vsh_d    = dec_v[260:256];
          lim_d    = dec_l[BIG_W-1:0];
          lsh_d    = dec_l[260:256];
          state_d  = S_SUM;
        end
      end
      S_SUM: begin
        // hist_q rotates by one each cycle; tap 0 is entry ctr_q.
        if (ctr_q < 8'(hcnt_q)) begin
          if (ctr_q < 8'd5) a5_d = a5_q + d_sum;
          if (ctr_q < 8'd7) a7_d = a7_q + d_sum;
          if (ctr_q < 8'd9) a9_d = a9_q + d_sum;
          a17_d    = a17_q + d_sum;
          oldest_d = hist_q[0];
        end
        newer_d = hist_q[0];
        ctr_d   = ctr_q + 8'd1;
        if (ctr_q == 8'(HIST_DEPTH - 1)) begin
          state_d = S_SCHED;
        end
      end
      S_SCHED: begin
        if (oldest_q == 32'd0) begin
          sched_d = $signed(DW'(gen_q));
        end else begin
          sched_d = $signed(DW'(oldest_q)) + $signed(DW'(cnt_sp));
        end
        if (hcnt_q == 5'd0) begin
          a5_d  = sp_s;
          a7_d  = sp_s;
          a9_d  = sp_s;
          a17_d = sp_s;
        end
        op_d    = OP_A5;
        state_d = S_DSTART;
      end
      S_DSTART: begin
        state_d = S_DWAIT;
      end
      S_DWAIT: begin
        if (drsp.done) begin
          state_d = S_DSTART;
          op_d    = op_q + 4'd1;
          case (op_q)
            OP_A5:    a5_d   = drsp.quot;
            OP_A7:    a7_d   = drsp.quot;
            OP_A9:    a9_d   = drsp.quot;
            OP_A17:   a17_d  = drsp.quot;
            OP_FAST:  fast_d = drsp.quot;
            OP_SLOW: begin
              slow_d  = drsp.quot;
              state_d = S_WANT;
            end
            OP_BLEND: begin
              want_d = drsp.quot;
              op_d   = OP_TF;
            end
            OP_TF:    tf_d   = drsp.quot;
            OP_TS: begin
              ts_d    = drsp.quot;
              state_d = S_MODE;
            end
            OP_FACT: begin
              factor_d = drsp.quot[32:0];
              if (drsp.quot <= 0) fault_d = 1'b1;
              state_d = S_PREP;
            end
            default: state_d = S_PREP;
          endcase
        end
      end
      S_WANT: begin
        // Blend toward the schedule when within one adjust interval of it.
        op_d    = OP_TF;
        state_d = S_DSTART;
        if ((now_s < sched_q + ai_s) && (now_s > sched_q)) begin
          bnum_d = DW'(bprod_a) + DW'(bprod_b);
          op_d   = OP_BLEND;
        end else if ((now_s + ai_s > sched_q) && (now_s < sched_q)) begin
          bnum_d = DW'(bprod_a) + DW'(bprod_b);
          op_d   = OP_BLEND;
        end else if (now_s < sched_q) begin
          want_d = slow_q;
        end else if (now_s > sched_q) begin
          want_d = fast_q;
        end else begin
          want_d = sp_s;
        end
      end
      S_MODE: begin
        factor_d = FACTOR_ONE;
        state_d  = S_PREP;
        if (c_eu) begin
          mode_d = MODE_EMERG_UP;
          if (a5_q > a7_q && a5_q > a9_q) reg_sel = a5_q;
          else if (a7_q > a9_q)           reg_sel = a7_q;
          else                            reg_sel = a9_q;
          num_d = tf_q <<< 2;
          den_d = reg_sel + tf_q * DW'(3);
        end else if (c_ed) begin
          mode_d = MODE_EMERG_DN;
          if (a5_q < a7_q && a5_q < a9_q) reg_sel = a5_q;
          else if (a7_q < a9_q)           reg_sel = a7_q;
          else                            reg_sel = a9_q;
          num_d = ts_q <<< 2;
          den_d = reg_sel + ts_q * DW'(3);
        end else if (c_u) begin
          mode_d = MODE_UP;
          if (a5_q > a7_q && a5_q > a9_q && a5_q > a17_q) reg_sel = a5_q;
          else if (a7_q > a9_q && a7_q > a17_q)           reg_sel = a7_q;
          else if (a9_q > a17_q)                          reg_sel = a9_q;
          else                                            reg_sel = a17_q;
          num_d = want_q <<< 2;
          den_d = reg_sel + want_q * DW'(3);
        end else if (c_dn) begin
          mode_d = MODE_DN;
          if (a5_q < a7_q && a5_q < a9_q && a5_q < a17_q) reg_sel = a5_q;
          else if (a7_q < a9_q && a7_q < a17_q)           reg_sel = a7_q;
          else if (a9_q < a17_q)                          reg_sel = a9_q;
          else                                            reg_sel = a17_q;
          num_d = want_q <<< 2;
          den_d = reg_sel + want_q * DW'(3);
        end
        if (c_eu || c_ed || c_u || c_dn) begin
          if (den_d <= 0) begin
            fault_d = 1'b1;
          end else begin
            op_d    = OP_FACT;
            state_d = S_DSTART;
          end
        end
      end
      S_PREP: begin
        mul_d   = 14'd1;
        carry_d = '0;
        gt_d    = 1'b0;
        ctr_d   = '0;
        rem_d   = '0;
        state_d = S_MUL;
        if (fault_q) begin
          val_d = lim_q;
        end else if (factor_q != FACTOR_ONE) begin
          mul_d   = 14'(SCALE);
          state_d = S_BIG;
        end
      end
      S_BIG: begin
        // Restoring long division, one quotient bit a cycle.
        if (btrial >= {1'b0, factor_q}) begin
          rem_d = bdiff[32:0];
          val_d = {val_q[BIG_W-2:0], 1'b1};
        end else begin
          rem_d = btrial[32:0];
          val_d = {val_q[BIG_W-2:0], 1'b0};
        end
        ctr_d = ctr_q + 8'd1;
        if (ctr_q == 8'd255) begin
          ctr_d   = '0;
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        // Word-serial scale and compare against the limit, low word first.
        val_d   = {prod[31:0], val_q[BIG_W-1:32]};
        lim_d   = {lim_q[31:0], lim_q[BIG_W-1:32]};
        carry_d = prod[45:32];
        if (prod[31:0] > lim_q[31:0]) begin
          gt_d = 1'b1;
        end else if (prod[31:0] < lim_q[31:0]) begin
          gt_d = 1'b0;
        end
        ctr_d = ctr_q + 8'd1;
        if (ctr_q == 8'd7) begin
          state_d = S_CLAMP;
        end
      end
      S_CLAMP: begin
        if (gt_q) val_d = lim_q;
        ctr_d   = '0;
        state_d = S_ENC;
      end
      S_ENC: begin
        // Normalize: drop leading zero bytes.
        if (val_q[BIG_W-1 -: 8] == 8'd0 && ctr_q < 8'd32) begin
          val_d = {val_q[BIG_W-9:0], 8'd0};
          ctr_d = ctr_q + 8'd1;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          nbits_d     = {2'b00, nsize, comp};
          omode_d     = mode_q;
          ofault_d    = fault_q;
          out_valid_d = 1'b1;
          hcnt_d      = (hcnt_q < 5'(HIST_DEPTH)) ? hcnt_q + 5'd1 : hcnt_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= OP_A5;
      ctr_q       <= '0;
      hcnt_q      <= '0;
      vsh_q       <= '0;
      lsh_q       <= '0;
      out_valid_q <= 1'b0;
      sp_q        <= 17'd600;
      ai_q        <= 16'd2016;
      lim_c_q     <= 32'h1d00ffff;
      gen_q       <= 32'd0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      ctr_q       <= ctr_d;
      hcnt_q      <= hcnt_d;
      vsh_q       <= vsh_d;
      lsh_q       <= lsh_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_SPACING:  sp_q    <= cfg_data_i[16:0];
          REG_INTERVAL: ai_q    <= cfg_data_i[15:0];
          REG_LIMIT:    lim_c_q <= cfg_data_i;
          REG_GENESIS:  gen_q   <= cfg_data_i;
          default:      gen_q   <= gen_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    time_q   <= time_d;
    newer_q  <= newer_d;
    oldest_q <= oldest_d;
    a5_q     <= a5_d;
    a7_q     <= a7_d;
    a9_q     <= a9_d;
    a17_q    <= a17_d;
    sched_q  <= sched_d;
    fast_q   <= fast_d;
    slow_q   <= slow_d;
    want_q   <= want_d;
    bnum_q   <= bnum_d;
    tf_q     <= tf_d;
    ts_q     <= ts_d;
    num_q    <= num_d;
    den_q    <= den_d;
    factor_q <= factor_d;
    rem_q    <= rem_d;
    mul_q    <= mul_d;
    carry_q  <= carry_d;
    gt_q     <= gt_d;
    fault_q  <= fault_d;
    mode_q   <= mode_d;
    val_q    <= val_d;
    lim_q    <= lim_d;
    nbits_q  <= nbits_d;
    omode_q  <= omode_d;
    ofault_q <= ofault_d;
    // Timestamp ring: rotate while summing, push the new time on completion.
    if (state_q == S_SUM) begin
      for (int k = 0; k < HIST_DEPTH - 1; k++) begin
        hist_q[k] <= hist_q[k+1];
      end
      hist_q[HIST_DEPTH-1] <= hist_q[0];
    end else if (state_q == S_DONE && (!out_valid_q || out_ready_i)) begin
      for (int k = 1; k < HIST_DEPTH; k++) begin
        hist_q[k] <= hist_q[k-1];
      end
      hist_q[0] <= time_q;
    end
  end

  // The long division runs only on a valid factor other than one.
  `ASSERT_IMPLY(a_big_div_needed, clk_i, rst_ni, state_q == S_BIG, !fault_q && factor_q != FACTOR_ONE)
  // Compact decodes are finished before the target is scaled.
  `ASSERT_IMPLY(a_decode_done, clk_i, rst_ni, state_q == S_MUL, vsh_q == 5'd0 && lsh_q == 5'd0)
  // An accepted item starts the timestamp walk.
  `ASSERT_NEXT(a_accept_sum, clk_i, rst_ni, in_acc, state_q == S_SUM && ctr_q == 8'd0)
  // History count saturates at the ring depth.
  `ASSERT_IMPLY(a_hcnt_range, clk_i, rst_ni, 1'b1, hcnt_q <= 5'(HIST_DEPTH))

endmodule
`default_nettype wire
